// File: design/ord_pkg.sv
// Shared types and constants for the overwriting ring deque.
// No dependencies; imported by the controller, datapath and top level.
package ord_pkg;

  // Width of the capacity register and its value after reset
  localparam int unsigned CAP_W     = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Word width of the buffer
  localparam int unsigned WORD_W = 32;

  // Operation codes carried on in_func
  typedef enum logic [1:0] {
    FUNC_PUSH_BACK = 2'd0,
    FUNC_POP_FRONT = 2'd1,
    FUNC_POP_BACK  = 2'd2,
    FUNC_NOP       = 2'd3
  } func_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture the incoming item
    logic exec;   // update pointers and access slot memory
  } ord_cmd_t;

endpackage

// File: design/ord_ctrl.sv
// Controller state machine for the overwriting ring deque.
// Depends on ord_pkg for the command struct.
module ord_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  output logic            out_valid,
  output ord_pkg::ord_cmd_t cmd
);
  import ord_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_t;

  state_t state_r;
  logic   busy_r;
  logic   out_valid_r;

  // Sequence one item: accept, execute, present the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_EXEC;
            busy_r  <= 1'b1;
          end
        end
        ST_EXEC: begin
          state_r     <= ST_RESP;
          out_valid_r <= 1'b1;
        end
        ST_RESP: begin
          state_r     <= ST_IDLE;
          out_valid_r <= 1'b0;
          busy_r      <= 1'b0;
        end
        default: begin
          state_r     <= ST_IDLE;
          busy_r      <= 1'b0;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  // Drive datapath commands
  always_comb begin
    cmd.load = start & ~busy_r;
    cmd.exec = (state_r == ST_EXEC);
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

endmodule

// File: design/ord_dp.sv
// Datapath of the overwriting ring deque: capacity register, pointers,
// full flag and slot memory. Depends on ord_pkg for types and constants.
module ord_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ord_pkg::ord_cmd_t                cmd,
  input  logic                             cfg_we,
  input  logic [ord_pkg::CAP_W-1:0]        cfg_wdata,
  input  logic [1:0]                       in_func,
  input  logic signed [ord_pkg::WORD_W-1:0] in_value,
  output logic signed [ord_pkg::WORD_W-1:0] out_data,
  output logic                             out_status,
  output logic                             out_is_empty,
  output logic                             out_is_full
);
  import ord_pkg::*;

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW = ($clog2(DEPTH + 1) > CAP_W) ? $clog2(DEPTH + 1) : CAP_W;

  // Advance an index, wrapping at the live size
  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i,
                                             input logic [SW-1:0] sz);
    logic [SW-1:0] n;
    n = SW'(i) + SW'(1);
    return (n >= sz) ? '0 : IW'(n);
  endfunction

  logic [CAP_W-1:0]        cap_r;
  logic [IW-1:0]           head_r, tail_r;
  logic                    full_r;
  func_t                   func_r;
  logic signed [WORD_W-1:0] value_r;
  logic                    status_r, empty_r, flag_full_r, rd_sel_r;
  logic signed [WORD_W-1:0] rd_data_r;
  logic signed [WORD_W-1:0] mem [DEPTH];

  logic [SW-1:0] cap_ext, size;
  logic [IW-1:0] hd, tl, head_nxt, tail_nxt;
  logic          fl, full_nxt, status_nxt, empty_nxt;
  logic          mem_we, rd_en;
  logic [IW-1:0] waddr, raddr;

  // Clamp capacity into 1..DEPTH
  always_comb begin
    cap_ext = SW'(cap_r);
    if (cap_ext == '0) begin
      size = SW'(1);
    end else if (cap_ext > SW'(DEPTH)) begin
      size = SW'(DEPTH);
    end else begin
      size = cap_ext;
    end
  end

  // Compute the operation's pointer update and memory access
  always_comb begin
    if (SW'(head_r) >= size || SW'(tail_r) >= size) begin
      hd = '0;
      tl = '0;
      fl = 1'b0;
    end else begin
      hd = head_r;
      tl = tail_r;
      fl = full_r;
    end
    head_nxt   = hd;
    tail_nxt   = tl;
    full_nxt   = fl;
    status_nxt = 1'b0;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    waddr      = tl;
    raddr      = hd;
    case (func_r)
      FUNC_PUSH_BACK: begin
        mem_we = 1'b1;
        if (fl) begin
          waddr    = hd;
          head_nxt = next_idx(hd, size);
          tail_nxt = next_idx(tl, size);
        end else begin
          waddr    = tl;
          tail_nxt = next_idx(tl, size);
        end
        if (head_nxt == tail_nxt) begin
          full_nxt = 1'b1;
        end
      end
      FUNC_POP_FRONT, FUNC_POP_BACK: begin
        if (hd == tl && !fl) begin
          status_nxt = 1'b1;
        end else begin
          rd_en = 1'b1;
          if (func_r == FUNC_POP_FRONT) begin
            raddr    = hd;
            head_nxt = next_idx(hd, size);
          end else begin
            tail_nxt = (tl == '0) ? IW'(size - SW'(1)) : tl - IW'(1);
            raddr    = tail_nxt;
          end
          if (head_nxt == tail_nxt) begin
            head_nxt = '0;
            tail_nxt = '0;
          end
          full_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
    empty_nxt = (head_nxt == tail_nxt) && !full_nxt;
  end

  // Hold capacity, pointers and full flag; a capacity write empties the buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAP_RESET;
      head_r <= '0;
      tail_r <= '0;
      full_r <= 1'b0;
    end else if (cfg_we) begin
      cap_r  <= cfg_wdata;
      head_r <= '0;
      tail_r <= '0;
      full_r <= 1'b0;
    end else if (cmd.exec) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      full_r <= full_nxt;
    end
  end

  // Capture the item and the result fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= func_t'(in_func);
      value_r <= in_value;
    end
    if (cmd.exec) begin
      status_r    <= status_nxt;
      empty_r     <= empty_nxt;
      flag_full_r <= full_nxt;
      rd_sel_r    <= rd_en;
    end
  end

  // Slot memory: one write or one registered read per item
  always_ff @(posedge clk) begin
    if (cmd.exec && mem_we) begin
      mem[waddr] <= value_r;
    end
    if (cmd.exec && rd_en) begin
      rd_data_r <= mem[raddr];
    end
  end

  assign out_data     = rd_sel_r ? rd_data_r : '0;
  assign out_status   = status_r;
  assign out_is_empty = empty_r;
  assign out_is_full  = flag_full_r;

endmodule

// File: design/overwriting_ring_deque_unit.sv
// Top level of the overwriting ring deque: controller plus datapath.
// Depends on ord_pkg, ord_ctrl and ord_dp.
//
//  channel  handshake          payload
//  -------  -----------------  ---------------------------------------------
//  input    start && !busy     in_func, in_value
//  result   out_valid (1 cyc)  out_data, out_status, out_is_empty, out_is_full
//  config   cfg_we             cfg_wdata (capacity)
//
// Each item passes through accept, the pointer update and slot memory access
// in ST_EXEC, then the result on the ports in ST_RESP. The slot memory has
// a registered read port.
// busy stays high from accept until the result cycle ends.
// Reset is synchronous, active low: capacity 16, buffer empty.
// The receiver cannot stall; each result is shown for one cycle only.
module overwriting_ring_deque_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       in_func,
  input  logic signed [ord_pkg::WORD_W-1:0] in_value,
  output logic                             out_valid,
  output logic signed [ord_pkg::WORD_W-1:0] out_data,
  output logic                             out_status,
  output logic                             out_is_empty,
  output logic                             out_is_full,
  input  logic                             cfg_we,
  input  logic [ord_pkg::CAP_W-1:0]        cfg_wdata
);
  import ord_pkg::*;

  ord_cmd_t cmd;

  ord_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  ord_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_func      (in_func),
    .in_value     (in_value),
    .out_data     (out_data),
    .out_status   (out_status),
    .out_is_empty (out_is_empty),
    .out_is_full  (out_is_full)
  );

`ifndef SYNTHESIS
  // An accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // A result appears only while an item is in flight
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside an item");

  // The buffer is never reported both empty and full
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_empty && out_is_full))
    else $error("empty and full reported together");

  // An empty pop returns zero and leaves the buffer empty
  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_is_empty && out_data == '0))
    else $error("empty pop result inconsistent");
`endif

endmodule

// File: sim/ord_checker.sv
`timescale 1ns / 1ps
// Checker for the overwriting ring deque: watches the input, result and config ports,
// predicts each result from its own copy of the ring state and compares.
// Depends on ord_pkg for the operation codes and widths.
module ord_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  logic [1:0]                        in_func,
  input  logic signed [ord_pkg::WORD_W-1:0] in_value,
  input  logic                              out_valid,
  input  logic signed [ord_pkg::WORD_W-1:0] out_data,
  input  logic                              out_status,
  input  logic                              out_is_empty,
  input  logic                              out_is_full,
  input  logic                              cfg_we,
  input  logic [ord_pkg::CAP_W-1:0]         cfg_wdata,
  output int                                fail_count,
  output int                                pending_count
);
  import ord_pkg::*;

  typedef struct packed {
    logic signed [WORD_W-1:0] data;
    logic                     status;
    logic                     is_empty;
    logic                     is_full;
  } deque_result_t;

  // Shadow copy of the ring
  logic signed [WORD_W-1:0] slot_mem [DEPTH];
  int unsigned              head_ptr;
  int unsigned              tail_ptr;
  bit                       full_q;
  logic [CAP_W-1:0]         cap_q;

  deque_result_t expected_results [$];
  int            mismatch_total = 0;
  int            queued_total = 0;

  assign fail_count    = mismatch_total;
  assign pending_count = queued_total;

  // Clamp the capacity register into 1..DEPTH
  function automatic int unsigned live_depth();
    int unsigned n;
    n = cap_q;
    if (n < 1) n = 1;
    if (n > DEPTH) n = DEPTH;
    return n;
  endfunction

  function automatic int unsigned ring_next(int unsigned i, int unsigned n);
    return (i + 1 >= n) ? 0 : i + 1;
  endfunction

  function automatic bit ring_empty();
    return (head_ptr == tail_ptr) && !full_q;
  endfunction

  function automatic void clear_ring();
    head_ptr = 0;
    tail_ptr = 0;
    full_q   = 1'b0;
  endfunction

  // Apply one operation to the shadow ring and return the result it produces
  function automatic deque_result_t apply_deque_op(func_t op, logic signed [WORD_W-1:0] word);
    deque_result_t r;
    int unsigned   n;
    n = live_depth();
    r = '0;
    if (head_ptr >= n || tail_ptr >= n) clear_ring();
    case (op)
      FUNC_PUSH_BACK: begin
        // when full, overwrite the oldest word and move both pointers on
        if (full_q) begin
          slot_mem[head_ptr] = word;
          head_ptr = ring_next(head_ptr, n);
          tail_ptr = ring_next(tail_ptr, n);
        end else begin
          slot_mem[tail_ptr] = word;
          tail_ptr = ring_next(tail_ptr, n);
        end
        if (head_ptr == tail_ptr) full_q = 1'b1;
      end
      FUNC_POP_FRONT, FUNC_POP_BACK: begin
        if (ring_empty()) begin
          r.status = 1'b1;
        end else begin
          if (op == FUNC_POP_FRONT) begin
            r.data   = slot_mem[head_ptr];
            head_ptr = ring_next(head_ptr, n);
          end else begin
            tail_ptr = (tail_ptr == 0) ? n - 1 : tail_ptr - 1;
            r.data   = slot_mem[tail_ptr];
          end
          // rewind both pointers once the ring drains
          if (head_ptr == tail_ptr) begin
            head_ptr = 0;
            tail_ptr = 0;
          end
          full_q = 1'b0;
        end
      end
      default: ;
    endcase
    r.is_empty = ring_empty();
    r.is_full  = full_q;
    return r;
  endfunction

  task automatic check_field(string name, logic signed [WORD_W-1:0] want,
                             logic signed [WORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatch_total++;
    end
  endtask

  // Track config writes, queue predictions for accepted items, compare results
  always @(posedge clk) begin
    deque_result_t want;
    if (!rst_n) begin
      clear_ring();
      cap_q = CAP_RESET;
      expected_results.delete();
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual data=%0d status=%0b",
                   $time, out_data, out_status);
          mismatch_total++;
        end else begin
          want = expected_results.pop_front();
          check_field("data", want.data, out_data);
          check_field("status", {31'd0, want.status}, {31'd0, out_status});
          check_field("is_empty", {31'd0, want.is_empty}, {31'd0, out_is_empty});
          check_field("is_full", {31'd0, want.is_full}, {31'd0, out_is_full});
        end
      end
      if (cfg_we) begin
        cap_q = cfg_wdata;
        clear_ring();
      end
      if (start && !busy)
        expected_results.push_back(apply_deque_op(func_t'(in_func), in_value));
    end
    queued_total = expected_results.size();
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for overwriting_ring_deque_unit: clock, reset, stimulus and verdict.
// Depends on ord_pkg, the block itself and ord_checker.
module tb_top;
  import ord_pkg::*;

  localparam int STALL_LIMIT = 1000;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [1:0]               in_func;
  logic signed [WORD_W-1:0] in_value;
  logic                     out_valid;
  logic signed [WORD_W-1:0] out_data;
  logic                     out_status;
  logic                     out_is_empty;
  logic                     out_is_full;
  logic                     cfg_we;
  logic [CAP_W-1:0]         cfg_wdata;

  int chk_fails;
  int chk_pending;
  int idle_cycles = 0;
  bit gaps_on = 1'b1;

  overwriting_ring_deque_unit #(.DEPTH(16)) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_func      (in_func),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .out_status   (out_status),
    .out_is_empty (out_is_empty),
    .out_is_full  (out_is_full),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  ord_checker #(.DEPTH(16)) chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_data      (out_data),
    .out_status    (out_status),
    .out_is_empty  (out_is_empty),
    .out_is_full   (out_is_full),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (chk_fails),
    .pending_count (chk_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("overwriting_ring_deque_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly short gaps, a few long ones, none while gaps are off
  function automatic int idle_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Favor the extreme words now and then
  function automatic logic signed [WORD_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Present one item from a falling edge, hold until accepted, then idle
  task automatic send_op(func_t op, logic signed [WORD_W-1:0] word);
    int gap;
    start    = 1'b1;
    in_func  = op;
    in_value = word;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start = 1'b0;
    gap = idle_gap();
    repeat (gap) @(negedge clk);
  endtask

  // Write the capacity once the block has drained
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    while (chk_pending != 0 || busy) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = cap;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    int phase_caps [11];
    int n;
    int sent;
    int len;
    int r;
    func_t op;

    rst_n     = 1'b0;
    start     = 1'b0;
    in_func   = FUNC_PUSH_BACK;
    in_value  = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    phase_caps = '{1, 2, 16, 3, 0, 31, 5, 8, 17, 16, 4};
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty pops, no-op, extreme words, both pop ends
    send_op(FUNC_POP_FRONT, 32'h1234_5678);
    send_op(FUNC_POP_BACK, 32'h0);
    send_op(FUNC_NOP, 32'hffff_ffff);
    send_op(FUNC_PUSH_BACK, 32'h8000_0000);
    send_op(FUNC_PUSH_BACK, 32'h7fff_ffff);
    send_op(FUNC_NOP, 32'h0);
    send_op(FUNC_POP_BACK, 32'h0);
    send_op(FUNC_POP_FRONT, 32'h0);
    send_op(FUNC_PUSH_BACK, 32'hffff_ffff);
    send_op(FUNC_PUSH_BACK, 32'h0000_0000);
    send_op(FUNC_PUSH_BACK, 32'h5555_5555);
    send_op(FUNC_PUSH_BACK, 32'haaaa_aaaa);
    send_op(FUNC_POP_FRONT, 32'h0);
    send_op(FUNC_POP_BACK, 32'h0);
    send_op(FUNC_POP_BACK, 32'h0);
    send_op(FUNC_POP_BACK, 32'h0);
    send_op(FUNC_POP_BACK, 32'h0);

    // Zero capacity acts as one: second push overwrites the first
    write_capacity(5'd0);
    send_op(FUNC_PUSH_BACK, 32'h0000_0001);
    send_op(FUNC_PUSH_BACK, 32'h0000_0002);
    send_op(FUNC_POP_BACK, 32'h0);
    send_op(FUNC_POP_FRONT, 32'h0);

    // Random phases: bursts that fill and overwrite, bursts that drain, mixed traffic
    for (int p = 0; p < 11; p++) begin
      write_capacity(phase_caps[p][CAP_W-1:0]);
      gaps_on = (p % 3 != 2);
      n = (phase_caps[p] < 1) ? 1 : ((phase_caps[p] > 16) ? 16 : phase_caps[p]);
      sent = 0;
      while (sent < 36) begin
        case ($urandom_range(0, 3))
          0: begin
            len = $urandom_range(1, n + 3);
            repeat (len) send_op(FUNC_PUSH_BACK, random_word());
            sent += len;
          end
          1: begin
            len = $urandom_range(1, n + 2);
            repeat (len) begin
              op = ($urandom_range(0, 1) == 1) ? FUNC_POP_FRONT : FUNC_POP_BACK;
              send_op(op, random_word());
            end
            sent += len;
          end
          default: begin
            r = $urandom_range(0, 99);
            if (r < 4) op = FUNC_NOP;
            else if (r < 55) op = FUNC_PUSH_BACK;
            else if (r < 78) op = FUNC_POP_FRONT;
            else op = FUNC_POP_BACK;
            send_op(op, random_word());
            sent++;
          end
        endcase
      end
    end

    // Drain, then wait a little longer for stray results
    while (chk_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (chk_fails == 0 && chk_pending == 0)
      $display("overwriting_ring_deque_unit verification clean");
    else
      $display("overwriting_ring_deque_unit verification failed");
    $finish;
  end

endmodule
